@@ rtl/core/tce_pkg.sv @@
`default_nettype none
package tce_pkg;
  localparam int MAX_COLS_D = 80;
  localparam int MAX_ROWS_D = 25;
  localparam int CONSOLES_D = 8;
  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam logic [7:0] ATTR_RESET = 8'h0F;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

  typedef enum logic [2:0] {
    OP_PUT = 3'd0, OP_PAGE = 3'd1, OP_COLOUR = 3'd2, OP_CLEAR = 3'd3, OP_READ = 3'd4
  } op_t;

  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
endpackage
`default_nettype wire

@@ rtl/core/tce_ram.sv @@
`default_nettype none
module tce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/text_console_engine.sv @@
`default_nettype none
// Text console engine: CONSOLES consoles share one cell memory (stride
// MAX_COLS*MAX_ROWS cells, one read and one write port). Each word in gives
// exactly one word out carrying the cursor and display start registers and,
// for a cell read, the cell. Show page, set colour, control characters,
// unknown operations and words for an absent console pass from acceptance
// to the result word through accept, decode and output; a printable byte
// adds one cell write and an in-range cell read adds a registered memory read.
// A scroll moves the columns*(rows-1) kept cells with one read and one write
// each, through the states S_SCR_RD, S_SCR_WR and S_RD_DATA per cell, then
// blanks the bottom line one cell a cycle; clear writes columns*rows cells,
// one a cycle. A stalled output holds the result word and the input stays
// closed until it is taken. After reset a clearing pass writes blank to all
// CONSOLES*MAX_COLS*MAX_ROWS cells, one a cycle, before the first word is taken.
module text_console_engine
  import tce_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_D,
  parameter int MAX_ROWS = MAX_ROWS_D,
  parameter int CONSOLES = CONSOLES_D
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // operation[2:0], console[5:3], char_code[13:6], argument[21:14], cell_index[32:22]
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tlast,   // end_of_write
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cursor_location[10:0], display_start[24:11], cell_value[40:25]
  output logic      [47:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [tce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [6:0]  cfg_data
);
  localparam int CPC = MAX_COLS * MAX_ROWS;
  localparam int DEPTH = CONSOLES * CPC;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(CPC + 1);
  localparam int NW = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DEC, S_SCR_RD, S_SCR_WR, S_BLANK, S_WRITE, S_CLEAR, S_RD_WAIT,
    S_RD_DATA, S_OUT
  } state_t;

  state_t state_r;
  logic [6:0] cols_r;
  logic [4:0] rows_r;
  logic [6:0] col_r [CONSOLES];
  logic [4:0] row_r [CONSOLES];
  logic [7:0] attr_r [CONSOLES];
  logic [10:0] cursor_r;
  logic [13:0] start_r;
  logic [15:0] value_r;
  logic [AW-1:0] waddr_r, raddr_r;
  logic [15:0] wdata_r;
  logic we_r;
  logic [AW-1:0] base_r;
  logic [CW-1:0] cnt_r, lim_r;
  logic [6:0] ncol_r, col_w;
  logic [4:0] nrow_r, row_w;
  logic [2:0] op_r;
  logic [NW-1:0] con_r;
  logic con_ok_r;
  logic [7:0] ch_r, arg_r;
  logic [10:0] idx_r;
  logic [15:0] rdata;
  logic [13:0] prod_r;

  logic [6:0] nc;
  logic [4:0] nr;
  always_comb begin
    nc = (cols_r == 7'd0) ? 7'd1 : (32'(cols_r) > MAX_COLS) ? 7'(MAX_COLS) : cols_r;
    nr = (rows_r == 5'd0) ? 5'd1 : (32'(rows_r) > MAX_ROWS) ? 5'(MAX_ROWS) : rows_r;
  end

  tce_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we_r), .waddr(waddr_r), .wdata(wdata_r), .raddr(raddr_r), .rdata(rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign cfg_ready = 1'b1;
  assign out_tdata = {7'd0, value_r, start_r, cursor_r};

  // per-item decode helpers
  logic [6:0] cur_c;
  logic [4:0] cur_r;
  logic [7:0] tab_c;
  always_comb begin
    cur_c = col_r[con_r];
    cur_r = row_r[con_r];
    tab_c = (8'(cur_c) + 8'd7) & 8'hF8;
  end

  always_ff @(posedge clk) begin
    we_r <= 1'b0;
    if (!rst_n) begin
      state_r <= S_INIT;
      cols_r <= 7'd80;
      rows_r <= 5'd25;
      cursor_r <= '0;
      start_r <= '0;
      cnt_r <= '0;
      con_r <= '0;
      for (int i = 0; i < CONSOLES; i++) begin
        col_r[i] <= '0; row_r[i] <= '0; attr_r[i] <= ATTR_RESET;
      end
      waddr_r <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_COLUMNS) cols_r <= cfg_data;
        else if (cfg_index == REG_ROWS) rows_r <= cfg_data[4:0];
      end
      case (state_r)
        S_INIT: begin
          we_r <= 1'b1; wdata_r <= BLANK_CELL;
          waddr_r <= AW'(cnt_r) + AW'(32'(con_r) * CPC);
          if (32'(cnt_r) == CPC - 1) begin
            cnt_r <= '0;
            if (32'(con_r) == CONSOLES - 1) state_r <= S_IDLE;
            con_r <= con_r + 1'b1;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tdata[2:0];
          con_r <= NW'(in_tdata[5:3]);
          con_ok_r <= 32'(in_tdata[5:3]) < CONSOLES;
          ch_r <= in_tdata[13:6]; arg_r <= in_tdata[21:14]; idx_r <= in_tdata[32:22];
          prod_r <= 14'(nc) * 14'(nr);
          value_r <= '0;
          state_r <= S_DEC;
        end
        S_DEC: begin
          base_r <= AW'(32'(con_r) * CPC);
          ncol_r <= nc; nrow_r <= nr;
          state_r <= S_OUT;
          if (con_ok_r) begin
            case (op_t'(op_r))
              OP_PUT: begin
                if (ch_r == CH_BS) begin
                  if (cur_c != 0) col_r[con_r] <= cur_c - 1'b1;
                end else if (ch_r == CH_CR) col_r[con_r] <= '0;
                else if (ch_r == CH_LF) begin
                  col_r[con_r] <= '0;
                  row_r[con_r] <= (6'(cur_r) + 6'd1 < 6'(nr)) ? cur_r + 1'b1 : nr;
                end else if (ch_r == CH_TAB) begin
                  col_r[con_r] <= (tab_c > 8'(nc)) ? nc : tab_c[6:0];
                end else begin
                  col_w <= (cur_c >= nc) ? 7'd0 : cur_c;
                  row_w <= (cur_c >= nc) ? cur_r + 1'b1 : cur_r;
                  if (((cur_c >= nc) ? 6'(cur_r) + 6'd1 : 6'(cur_r)) >= 6'(nr)) begin
                    cnt_r <= '0;
                    lim_r <= CW'(nc) * CW'(nr - 1'b1);
                    state_r <= S_SCR_RD;
                  end else state_r <= S_WRITE;
                end
              end
              OP_PAGE: start_r <= 14'(arg_r[2:0] * prod_r);
              OP_COLOUR: attr_r[con_r] <= arg_r;
              OP_CLEAR: begin cnt_r <= '0; lim_r <= CW'(prod_r); state_r <= S_CLEAR; end
              OP_READ: if (32'(idx_r) < CPC) begin
                raddr_r <= AW'(32'(con_r) * CPC) + AW'(idx_r);
                state_r <= S_RD_WAIT;
              end
              default: ;
            endcase
          end
        end
        S_SCR_RD: begin
          if (cnt_r == lim_r) begin cnt_r <= '0; state_r <= S_BLANK; end
          else begin raddr_r <= base_r + AW'(cnt_r) + AW'(ncol_r); state_r <= S_SCR_WR; end
        end
        S_SCR_WR: state_r <= S_RD_DATA;
        S_RD_DATA: begin
          if (op_t'(op_r) == OP_READ) begin value_r <= rdata; state_r <= S_OUT; end
          else begin
            we_r <= 1'b1; wdata_r <= rdata; waddr_r <= base_r + AW'(cnt_r);
            cnt_r <= cnt_r + 1'b1; state_r <= S_SCR_RD;
          end
        end
        S_BLANK: begin
          we_r <= 1'b1; wdata_r <= BLANK_CELL; waddr_r <= base_r + AW'(lim_r) + AW'(cnt_r);
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(ncol_r) - 1'b1) begin
            row_w <= nrow_r - 1'b1; state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          we_r <= 1'b1;
          wdata_r <= {attr_r[con_r], ch_r};
          waddr_r <= base_r + AW'(col_w) + AW'(row_w) * AW'(ncol_r);
          cursor_r <= 11'(col_w + 1 + row_w * ncol_r);
          col_r[con_r] <= col_w + 1'b1;
          row_r[con_r] <= row_w;
          state_r <= S_OUT;
        end
        S_CLEAR: begin
          if (cnt_r == lim_r) state_r <= S_OUT;
          else begin
            we_r <= 1'b1; wdata_r <= BLANK_CELL; waddr_r <= base_r + AW'(cnt_r);
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_RD_WAIT: state_r <= S_RD_DATA;
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input and output open together");
  a_val_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && op_r != OP_READ) |-> value_r == '0) else $error("stray cell value");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

@@ sim/text_console_engine_test.sv @@
`timescale 1ns / 1ps
module text_console_engine_test;
  import tce_pkg::*;

  localparam int NCOLS = MAX_COLS_D;
  localparam int NROWS = MAX_ROWS_D;
  localparam int NCONS = CONSOLES_D;
  localparam int STRIDE = NCOLS * NROWS;
  localparam int WATCHDOG = 200000;  // covers the clearing pass after reset too

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COLUMNS;
  logic [6:0] cfg_data = '0;

  always #6 clk = ~clk;

  text_console_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [15:0] cval;
    logic [13:0] start;
    logic [10:0] cursor;
  } status_t;

  // Shadow console state
  logic [15:0] cells [NCONS*STRIDE];
  int unsigned col_q [NCONS];
  int unsigned row_q [NCONS];
  logic [7:0] colour_q [NCONS];
  logic [10:0] cursor_q;
  logic [13:0] start_q;
  logic [6:0] columns_q;
  logic [4:0] rows_q;

  status_t status_due [$];
  int fails = 0;
  int idle_pct = 18;
  int quiet = 0;

  // Clamped geometry
  function automatic int unsigned geo_cols();
    if (columns_q < 1) return 1;
    if (columns_q > NCOLS) return NCOLS;
    return columns_q;
  endfunction

  function automatic int unsigned geo_rows();
    if (rows_q < 1) return 1;
    if (rows_q > NROWS) return NROWS;
    return rows_q;
  endfunction

  task automatic console_reset();
    foreach (cells[i]) cells[i] = BLANK_CELL;
    for (int i = 0; i < NCONS; i++) begin
      col_q[i] = 0; row_q[i] = 0; colour_q[i] = ATTR_RESET;
    end
    cursor_q = '0; start_q = '0; columns_q = 7'd80; rows_q = 5'd25;
  endtask

  function automatic void shadow_putc(int unsigned con, logic [7:0] ch);
    int unsigned nc, nr, c, r, base;
    nc = geo_cols(); nr = geo_rows();
    c = col_q[con]; r = row_q[con]; base = con * STRIDE;
    if (ch == CH_BS) begin
      if (c > 0) c--;
    end else if (ch == CH_CR) begin
      c = 0;
    end else if (ch == CH_LF) begin
      c = 0;
      r = (r + 1 < nr) ? r + 1 : nr;
    end else if (ch == CH_TAB) begin
      c = ((c + 7) / 8) * 8;
      if (c > nc) c = nc;
    end else begin
      if (c >= nc) begin
        c = 0; r++;
      end
      if (r >= nr) begin
        // scroll up one line, blank the bottom
        for (int unsigned i = 0; i < nc * (nr - 1); i++) cells[base+i] = cells[base+i+nc];
        for (int unsigned i = 0; i < nc; i++) cells[base + nc*(nr-1) + i] = BLANK_CELL;
        r = nr - 1;
      end
      cells[base + c + r*nc] = {colour_q[con], ch};
      cursor_q = 11'((c + 1 + r * nc) & 11'h7FF);
      c++;
    end
    col_q[con] = c; row_q[con] = r;
  endfunction

  function automatic status_t console_apply(logic [39:0] w);
    logic [2:0] op;
    int unsigned con, idx;
    logic [7:0] ch, arg;
    status_t s;
    op = w[2:0]; con = w[5:3]; ch = w[13:6]; arg = w[21:14]; idx = w[32:22];
    s.cval = '0;
    if (con < NCONS) begin
      case (op)
        OP_PUT: shadow_putc(con, ch);
        OP_PAGE: start_q = 14'((arg[2:0] * geo_cols() * geo_rows()) & 14'h3FFF);
        OP_COLOUR: colour_q[con] = arg;
        OP_CLEAR: begin
          for (int unsigned i = 0; i < geo_cols() * geo_rows(); i++)
            cells[con*STRIDE + i] = BLANK_CELL;
        end
        OP_READ: if (idx < STRIDE) s.cval = cells[con*STRIDE + idx];
        default: ;
      endcase
    end
    s.cursor = cursor_q; s.start = start_q;
    return s;
  endfunction

  function automatic logic [39:0] pack_word(logic [2:0] op, logic [2:0] con, logic [7:0] ch,
                                            logic [7:0] arg, logic [10:0] idx);
    return {7'd0, idx, arg, ch, con, op};
  endfunction

  // Send one word; predictor runs on acceptance. Optional typed expectation.
  // The word stays valid on return; the next call or drain() drops it.
  task automatic send_word(logic [39:0] w, logic last, bit has_fixed = 0,
                           status_t fixed = '0);
    status_t s;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= w; in_tlast <= last; in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    s = console_apply(w);
    if (has_fixed && s != fixed) begin
      fails++;
      if (fails <= 10) $display("table row disagrees with predictor: %h vs %h", fixed, s);
    end
    status_due.push_back(s);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_COLUMNS) columns_q = val; else rows_q = val[4:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Result checker and output stalls
  always @(posedge clk) begin
    status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[40:0];
      if (status_due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected word %h", got);
      end else begin
        want = status_due.pop_front();
        if (got.cursor != want.cursor || got.start != want.start || got.cval != want.cval) begin
          fails++;
          if (fails <= 10)
            $display("mismatch cursor %0d/%0d start %0d/%0d cell %h/%h (exp/act)",
                     want.cursor, got.cursor, want.start, got.start, want.cval, got.cval);
        end
      end
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= idle_pct);

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  typedef struct {
    logic [2:0] op; logic [2:0] con; logic [7:0] ch; logic [7:0] arg; logic [10:0] idx;
    bit fixed; status_t want;
  } row_t;

  row_t plan [$];

  function automatic row_t mk(logic [2:0] op, logic [2:0] con, logic [7:0] ch,
                              logic [7:0] arg, logic [10:0] idx,
                              bit fixed = 0, status_t want = '0);
    row_t r;
    r.op = op; r.con = con; r.ch = ch; r.arg = arg; r.idx = idx; r.fixed = fixed; r.want = want;
    return r;
  endfunction

  task automatic random_item();
    int k;
    logic [7:0] ch;
    k = $urandom_range(99);
    ch = 8'($urandom);
    if (k < 55) begin
      // mostly printable text with some control bytes
      case ($urandom_range(7))
        0: ch = CH_LF;
        1: ch = CH_TAB;
        2: ch = CH_BS;
        3: ch = CH_CR;
        default: ;
      endcase
      send_word(pack_word(OP_PUT, 3'($urandom_range(7)), ch, 8'($urandom), 11'($urandom)),
                1'($urandom));
    end else if (k < 75)
      send_word(pack_word(OP_READ, 3'($urandom_range(7)), 8'($urandom), 8'($urandom),
                          ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(300))),
                1'($urandom));
    else if (k < 98)
      send_word(pack_word(3'($urandom_range(2) == 0 ? OP_PAGE : OP_COLOUR),
                          3'($urandom_range(7)), 8'($urandom), 8'($urandom), 11'($urandom)),
                1'($urandom));
    else
      send_word(pack_word(($urandom_range(1) ? OP_CLEAR : 3'($urandom_range(5, 7))),
                          3'($urandom_range(7)), 8'($urandom), 8'($urandom), 11'($urandom)),
                1'($urandom));
  endtask

  initial begin
    console_reset();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: reset state, extremes, control chars, special cases
    plan.push_back(mk(OP_READ, 0, 0, 0, 0, 1, '{cval: BLANK_CELL, start: 0, cursor: 0}));
    plan.push_back(mk(OP_READ, 7, 0, 0, 11'd1999, 1, '{cval: BLANK_CELL, start: 0, cursor: 0}));
    plan.push_back(mk(OP_READ, 3, 0, 0, 11'd2047, 1, '{cval: 0, start: 0, cursor: 0}));
    plan.push_back(mk(OP_PUT, 0, 8'h41, 0, 0, 1, '{cval: 0, start: 0, cursor: 1}));
    plan.push_back(mk(OP_READ, 0, 0, 0, 0, 1, '{cval: 16'h0F41, start: 0, cursor: 1}));
    plan.push_back(mk(OP_PAGE, 0, 0, 8'hFF, 0, 1, '{cval: 0, start: 14000, cursor: 1}));
    plan.push_back(mk(OP_COLOUR, 1, 0, 8'hFF, 0));
    plan.push_back(mk(OP_PUT, 1, 8'hFF, 0, 0));
    plan.push_back(mk(OP_PUT, 1, CH_BS, 0, 0));
    plan.push_back(mk(OP_PUT, 1, CH_BS, 0, 0));
    plan.push_back(mk(OP_PUT, 1, CH_BS, 0, 0));
    plan.push_back(mk(OP_PUT, 1, CH_TAB, 0, 0));
    plan.push_back(mk(OP_PUT, 1, 8'h00, 0, 0));
    plan.push_back(mk(OP_PUT, 1, CH_TAB, 0, 0));
    plan.push_back(mk(OP_PUT, 1, CH_CR, 0, 0));
    plan.push_back(mk(OP_PUT, 1, CH_LF, 0, 0));
    plan.push_back(mk(OP_READ, 1, 0, 0, 0));
    plan.push_back(mk(OP_CLEAR, 1, 0, 0, 0));
    plan.push_back(mk(OP_READ, 1, 0, 0, 0));
    plan.push_back(mk(3'd5, 2, 8'h41, 8'h07, 0));
    plan.push_back(mk(3'd7, 2, 8'h41, 8'h07, 0));
    plan.push_back(mk(OP_PUT, 2, 8'h7F, 8'h00, 11'h7FF));
    foreach (plan[i])
      send_word(pack_word(plan[i].op, plan[i].con, plan[i].ch, plan[i].arg, plan[i].idx),
                i[0], plan[i].fixed, plan[i].want);

    // Hold off until everything is back
    drain();

    // Small geometry: newline saturation, row past bottom, scroll, wrap
    write_reg(REG_COLUMNS, 7'd3);
    write_reg(REG_ROWS, 5'd2);
    for (int i = 0; i < 60; i++) random_item();
    drain();
    // Zero and oversized values clamp
    write_reg(REG_COLUMNS, 7'd0);
    write_reg(REG_ROWS, 5'd0);
    for (int i = 0; i < 60; i++) random_item();
    drain();
    write_reg(REG_COLUMNS, 7'd127);
    write_reg(REG_ROWS, 5'd31);
    idle_pct = 0;  // no idling in this stretch
    for (int i = 0; i < 150; i++) random_item();
    drain();
    idle_pct = 18;
    write_reg(REG_COLUMNS, 7'd1);
    write_reg(REG_ROWS, 5'd1);
    for (int i = 0; i < 60; i++) random_item();
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_COLUMNS, 7'($urandom_range(1, 20)));
      write_reg(REG_ROWS, 5'($urandom_range(1, 8)));
      for (int i = 0; i < 70; i++) random_item();
      drain();
    end

    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/tce_pkg.sv
rtl/core/tce_ram.sv
rtl/core/text_console_engine.sv
sim/text_console_engine_test.sv
